FILE: rtl/pvd_pkg.sv
// Package: types and constants shared by the posting varint delta decoder.
package pvd_pkg;

    localparam int DOC_ID_BITS      = 32;
    localparam int COUNT_W          = 32;
    localparam int VALUE_W          = 64;
    localparam int BYTE_IDX_W       = 4;
    localparam int SHIFT_W          = 6;
    localparam int MAX_VARINT_BYTES = 10;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_TOO_LONG   = 3'd1,
        STATUS_BAD_STRAND = 3'd2,
        STATUS_TRUNCATED  = 3'd3,
        STATUS_TRAILING   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FIELD_DOC    = 2'd0,
        FIELD_SEQ    = 2'd1,
        FIELD_POS    = 2'd2,
        FIELD_STRAND = 2'd3
    } field_t;

    typedef struct packed {
        logic                   emit;
        logic                   posting_valid;
        logic [DOC_ID_BITS-1:0] doc_id;
        logic [VALUE_W-1:0]     seq_id;
        logic [VALUE_W-1:0]     position;
        logic                   strand;
        logic                   block_done;
        status_t                status;
    } result_t;

endpackage

FILE: rtl/pvd_if.sv
// Interfaces: compressed byte channel and decoded posting channel.
interface pvd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_end;

    modport source (output valid, output data_byte, output block_end, input ready);
    modport sink (input valid, input data_byte, input block_end, output ready);
endinterface

interface pvd_post_if;
    logic                           valid;
    logic                           ready;
    logic                           posting_valid;
    logic [pvd_pkg::DOC_ID_BITS-1:0] doc_id;
    logic [pvd_pkg::VALUE_W-1:0]    seq_id;
    logic [pvd_pkg::VALUE_W-1:0]    position;
    logic                           strand;
    logic                           block_done;
    pvd_pkg::status_t               status;

    modport source (
        output valid, output posting_valid, output doc_id, output seq_id,
        output position, output strand, output block_done, output status, input ready
    );
    modport sink (
        input valid, input posting_valid, input doc_id, input seq_id,
        input position, input strand, input block_done, input status, output ready
    );
endinterface

FILE: rtl/pvd_core.sv
// Decode core: varint assembly, delta rebuild and block error tracking.
module pvd_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [7:0]                  data_byte,
    input  logic                        block_end,
    input  logic [pvd_pkg::COUNT_W-1:0] expected_postings,
    output pvd_pkg::result_t            res
);

    logic [pvd_pkg::VALUE_W-1:0]     acc_reg, acc_next;
    logic [pvd_pkg::BYTE_IDX_W-1:0]  idx_reg, idx_next;
    pvd_pkg::field_t                 field_reg, field_next;
    logic [pvd_pkg::DOC_ID_BITS-1:0] doc_reg, doc_next;
    logic [pvd_pkg::VALUE_W-1:0]     seq_hold_reg, seq_hold_next;
    logic [pvd_pkg::VALUE_W-1:0]     pos_hold_reg, pos_hold_next;
    logic [pvd_pkg::DOC_ID_BITS-1:0] last_doc_reg, last_doc_next;
    logic [pvd_pkg::VALUE_W-1:0]     last_seq_reg, last_seq_next;
    logic [pvd_pkg::VALUE_W-1:0]     last_pos_reg, last_pos_next;
    logic [pvd_pkg::COUNT_W-1:0]     done_reg, done_next;
    pvd_pkg::status_t                err_reg, err_next;

    logic [pvd_pkg::SHIFT_W-1:0]     shamt;
    logic [pvd_pkg::VALUE_W-1:0]     value;
    logic                            first;
    logic                            doc_match;
    logic                            seq_match;
    logic [pvd_pkg::VALUE_W-1:0]     seq_calc;
    logic [pvd_pkg::VALUE_W-1:0]     pos_calc;
    logic                            post;

    // 7 * index, modulo 64
    assign shamt      = ({2'b00, idx_reg} << 3) - {2'b00, idx_reg};
    assign value      = acc_reg | ({{(pvd_pkg::VALUE_W-7){1'b0}}, data_byte[6:0]} << shamt);
    assign first      = (done_reg == '0);
    assign doc_match  = !first && (doc_reg == last_doc_reg);
    // seq equals last exactly when the delta is zero
    assign seq_match  = doc_match && (seq_hold_reg == '0);
    assign seq_calc   = doc_match ? (last_seq_reg + seq_hold_reg) : seq_hold_reg;
    assign pos_calc   = seq_match ? (last_pos_reg + pos_hold_reg) : pos_hold_reg;

    always_comb
    begin
        acc_next      = acc_reg;
        idx_next      = idx_reg;
        field_next    = field_reg;
        doc_next      = doc_reg;
        seq_hold_next = seq_hold_reg;
        pos_hold_next = pos_hold_reg;
        last_doc_next = last_doc_reg;
        last_seq_next = last_seq_reg;
        last_pos_next = last_pos_reg;
        done_next     = done_reg;
        err_next      = err_reg;
        post          = 1'b0;

        if (err_reg == pvd_pkg::STATUS_OK)
        begin
            if (done_reg >= expected_postings)
            begin
                err_next = pvd_pkg::STATUS_TRAILING;
            end
            else if (!data_byte[7])
            begin
                acc_next   = '0;
                idx_next   = '0;
                field_next = pvd_pkg::field_t'(field_reg + 2'd1);
                case (field_reg)
                    pvd_pkg::FIELD_DOC:
                    begin
                        doc_next = first ? value[pvd_pkg::DOC_ID_BITS-1:0]
                                         : last_doc_reg + value[pvd_pkg::DOC_ID_BITS-1:0];
                    end
                    pvd_pkg::FIELD_SEQ:
                    begin
                        seq_hold_next = value;
                    end
                    pvd_pkg::FIELD_POS:
                    begin
                        pos_hold_next = value;
                    end
                    default:
                    begin
                        if (|value[pvd_pkg::VALUE_W-1:1])
                        begin
                            err_next = pvd_pkg::STATUS_BAD_STRAND;
                        end
                        else
                        begin
                            post          = 1'b1;
                            last_doc_next = doc_reg;
                            last_seq_next = seq_calc;
                            last_pos_next = pos_calc;
                            done_next     = done_reg + pvd_pkg::COUNT_W'(1);
                        end
                    end
                endcase
            end
            else
            begin
                acc_next = value;
                idx_next = idx_reg + pvd_pkg::BYTE_IDX_W'(1);
                if (idx_reg >= pvd_pkg::BYTE_IDX_W'(pvd_pkg::MAX_VARINT_BYTES - 1))
                begin
                    err_next = pvd_pkg::STATUS_TOO_LONG;
                end
            end
        end

        res               = '0;
        res.emit          = post || block_end;
        res.block_done    = block_end;
        if (post)
        begin
            res.posting_valid = 1'b1;
            res.doc_id        = doc_reg;
            res.seq_id        = seq_calc;
            res.position      = pos_calc;
            res.strand        = value[0];
        end
        if (block_end)
        begin
            if (err_next == pvd_pkg::STATUS_OK && done_next < expected_postings)
                res.status = pvd_pkg::STATUS_TRUNCATED;
            else
                res.status = err_next;
            acc_next      = '0;
            idx_next      = '0;
            field_next    = pvd_pkg::FIELD_DOC;
            doc_next      = '0;
            seq_hold_next = '0;
            pos_hold_next = '0;
            last_doc_next = '0;
            last_seq_next = '0;
            last_pos_next = '0;
            done_next     = '0;
            err_next      = pvd_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            idx_reg      <= '0;
            field_reg    <= pvd_pkg::FIELD_DOC;
            doc_reg      <= '0;
            seq_hold_reg <= '0;
            pos_hold_reg <= '0;
            last_doc_reg <= '0;
            last_seq_reg <= '0;
            last_pos_reg <= '0;
            done_reg     <= '0;
            err_reg      <= pvd_pkg::STATUS_OK;
        end
        else if (fire)
        begin
            acc_reg      <= acc_next;
            idx_reg      <= idx_next;
            field_reg    <= field_next;
            doc_reg      <= doc_next;
            seq_hold_reg <= seq_hold_next;
            pos_hold_reg <= pos_hold_next;
            last_doc_reg <= last_doc_next;
            last_seq_reg <= last_seq_next;
            last_pos_reg <= last_pos_next;
            done_reg     <= done_next;
            err_reg      <= err_next;
        end
    end

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg > pvd_pkg::BYTE_IDX_W'(pvd_pkg::MAX_VARINT_BYTES - 1)
        |-> err_reg == pvd_pkg::STATUS_TOO_LONG)
        else $error("varint byte index past limit without error");

    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && block_end
        |=> done_reg == '0 && err_reg == pvd_pkg::STATUS_OK && field_reg == pvd_pkg::FIELD_DOC)
        else $error("block state not cleared after block end");

    a_err_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !block_end && err_reg != pvd_pkg::STATUS_OK
        |=> $stable(done_reg) && $stable(err_reg) && $stable(last_doc_reg))
        else $error("state changed while dropping bytes after error");

endmodule

FILE: rtl/posting_varint_delta_decoder.sv
// Top level: posting varint delta decoder with input and result registers.
// Takes one byte of a compressed posting block per item and returns at most one result per
// byte: a posting when the byte finishes the strand varint, and/or the block close with its
// status when block_end is set. A new byte is accepted every cycle unless a result stalls;
// the byte is captured in the input register and its result in the result register, and
// the decode step between them is bounded by the 64-bit sequence and position adders. A
// stalled result holds the input register, so at most one byte waits inside.
// expected_postings is sampled as each byte is decoded; write it only while no item
// is in flight.
module posting_varint_delta_decoder
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        expected_postings_we,
    input  logic [pvd_pkg::COUNT_W-1:0] expected_postings_wdata,
    pvd_byte_if.sink                    bytes,
    pvd_post_if.source                  postings
);

    logic                        in_v_reg;
    logic [7:0]                  in_byte_reg;
    logic                        in_end_reg;
    logic                        out_v_reg;
    pvd_pkg::result_t            out_reg;
    logic [pvd_pkg::COUNT_W-1:0] expected_reg;
    logic                        advance;
    logic                        fire;
    pvd_pkg::result_t            res;

    assign advance     = !out_v_reg || postings.ready;
    assign fire        = in_v_reg && advance;
    assign bytes.ready = !in_v_reg || advance;

    pvd_core u_core
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (fire),
        .data_byte         (in_byte_reg),
        .block_end         (in_end_reg),
        .expected_postings (expected_reg),
        .res               (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
            in_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (expected_postings_we)
                expected_reg <= expected_postings_wdata;
            if (bytes.ready)
                in_v_reg <= bytes.valid;
            if (advance)
                out_v_reg <= fire && res.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            in_byte_reg <= bytes.data_byte;
            in_end_reg  <= bytes.block_end;
        end
        if (fire && res.emit)
            out_reg <= res;
    end

    assign postings.valid         = out_v_reg;
    assign postings.posting_valid = out_reg.posting_valid;
    assign postings.doc_id        = out_reg.doc_id;
    assign postings.seq_id        = out_reg.seq_id;
    assign postings.position      = out_reg.position;
    assign postings.strand        = out_reg.strand;
    assign postings.block_done    = out_reg.block_done;
    assign postings.status        = out_reg.status;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_v_reg && !advance |=> in_v_reg && $stable(in_byte_reg) && $stable(in_end_reg))
        else $error("pending byte lost while result stalled");

endmodule

FILE: test/tb_top.sv
// Testbench for the posting varint delta decoder: directed and random byte blocks checked against a predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_end;
    } byte_item_t;

    typedef struct packed {
        logic                            posting_valid;
        logic [pvd_pkg::DOC_ID_BITS-1:0] doc_id;
        logic [pvd_pkg::VALUE_W-1:0]     seq_id;
        logic [pvd_pkg::VALUE_W-1:0]     position;
        logic                            strand;
        logic                            block_done;
        pvd_pkg::status_t                status;
    } posting_result_t;

    typedef enum int {
        BLOCK_CLEAN,
        BLOCK_SHORT,
        BLOCK_TRAILING,
        BLOCK_BAD_STRAND,
        BLOCK_OVERLONG,
        BLOCK_NOISE
    } block_kind_t;

    logic                        clk;
    logic                        rst_n;
    logic                        count_we;
    logic [pvd_pkg::COUNT_W-1:0] count_wdata;

    pvd_byte_if byte_ch ();
    pvd_post_if post_ch ();

    posting_varint_delta_decoder dut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .expected_postings_we    (count_we),
        .expected_postings_wdata (count_wdata),
        .bytes                   (byte_ch),
        .postings                (post_ch)
    );

    // decoder mirror
    logic [pvd_pkg::COUNT_W-1:0]     postings_target = '0;
    logic [pvd_pkg::VALUE_W-1:0]     word_acc        = '0;
    logic [pvd_pkg::BYTE_IDX_W-1:0]  word_bytes      = '0;
    logic [1:0]                      field_sel       = '0;
    logic [pvd_pkg::DOC_ID_BITS-1:0] doc_now         = '0;
    logic [pvd_pkg::VALUE_W-1:0]     seq_step        = '0;
    logic [pvd_pkg::VALUE_W-1:0]     pos_step        = '0;
    logic [pvd_pkg::DOC_ID_BITS-1:0] prev_doc        = '0;
    logic [pvd_pkg::VALUE_W-1:0]     prev_seq        = '0;
    logic [pvd_pkg::VALUE_W-1:0]     prev_pos        = '0;
    logic [pvd_pkg::COUNT_W-1:0]     postings_seen   = '0;
    pvd_pkg::status_t                block_error     = pvd_pkg::STATUS_OK;

    byte_item_t      byte_queue[$];
    byte_item_t      block_bytes[$];
    posting_result_t expected_q[$];
    posting_result_t predicted;
    posting_result_t want;
    byte_item_t      next_byte;

    int          items_pushed   = 0;
    int          items_accepted = 0;
    logic        byte_taken     = 1'b0;
    int          burst_left     = 1;
    int          gap_left       = 0;
    int          hold_requests  = 0;
    int          hold_served    = 0;
    int          hold_left      = 0;
    logic [7:0]  stall_pattern  = 8'hff;
    int          pattern_age    = 0;
    int          cycle_count    = 0;
    int          errors         = 0;
    int          postings_checked = 0;
    int          blocks_checked   = 0;
    int          status_count[5]  = '{default: 0};
    int          phase_no         = 0;

    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output posting_result_t r);
        logic [pvd_pkg::VALUE_W-1:0] word;
        logic [pvd_pkg::VALUE_W-1:0] seq_val;
        logic [pvd_pkg::VALUE_W-1:0] pos_val;
        logic                        first;
        logic                        doc_match;
        logic                        seq_match;
        r = '0;
        if (block_error == pvd_pkg::STATUS_OK)
        begin
            if (postings_seen >= postings_target)
                block_error = pvd_pkg::STATUS_TRAILING;
            else
            begin
                word_acc = word_acc | (64'(b[6:0]) << ((7 * int'(word_bytes)) & 63));
                if (!b[7])
                begin
                    word       = word_acc;
                    first      = (postings_seen == 0);
                    word_acc   = '0;
                    word_bytes = '0;
                    case (field_sel)
                        pvd_pkg::FIELD_DOC:
                            doc_now = first ? word[pvd_pkg::DOC_ID_BITS-1:0]
                                            : prev_doc + word[pvd_pkg::DOC_ID_BITS-1:0];
                        pvd_pkg::FIELD_SEQ: seq_step = word;
                        pvd_pkg::FIELD_POS: pos_step = word;
                        default:
                        begin
                            if (word > 64'd1)
                                block_error = pvd_pkg::STATUS_BAD_STRAND;
                            else
                            begin
                                doc_match = !first && doc_now == prev_doc;
                                seq_val   = doc_match ? prev_seq + seq_step : seq_step;
                                seq_match = doc_match && seq_val == prev_seq;
                                pos_val   = seq_match ? prev_pos + pos_step : pos_step;
                                r.posting_valid = 1'b1;
                                r.doc_id        = doc_now;
                                r.seq_id        = seq_val;
                                r.position      = pos_val;
                                r.strand        = word[0];
                                prev_doc        = doc_now;
                                prev_seq        = seq_val;
                                prev_pos        = pos_val;
                                postings_seen   = postings_seen + pvd_pkg::COUNT_W'(1);
                            end
                        end
                    endcase
                    field_sel = field_sel + 2'd1;
                end
                else
                begin
                    word_bytes = word_bytes + pvd_pkg::BYTE_IDX_W'(1);
                    if (word_bytes >= pvd_pkg::MAX_VARINT_BYTES)
                        block_error = pvd_pkg::STATUS_TOO_LONG;
                end
            end
        end
        if (last)
        begin
            if (block_error == pvd_pkg::STATUS_OK && postings_seen < postings_target)
                block_error = pvd_pkg::STATUS_TRUNCATED;
            r.block_done  = 1'b1;
            r.status      = block_error;
            word_acc      = '0;
            word_bytes    = '0;
            field_sel     = '0;
            doc_now       = '0;
            seq_step      = '0;
            pos_step      = '0;
            prev_doc      = '0;
            prev_seq      = '0;
            prev_pos      = '0;
            postings_seen = '0;
            block_error   = pvd_pkg::STATUS_OK;
        end
        return r.posting_valid || last;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (errors < 40)
            $display("MISMATCH at %0t: %s got %0h, wanted %0h", $time, what, got, exp_val);
        errors++;
    endtask

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: return 64'd0;
            1: return 64'($urandom_range(1, 300));
            2: return v;
            3: return '1;
            default: return v >> $urandom_range(1, 63);
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b);
        block_bytes.insert(block_bytes.size(), '{data_byte: b, block_end: 1'b0});
    endtask

    // shortest encoding, sometimes padded; a tenth byte may carry junk above bit 63
    task automatic put_varint(input logic [63:0] value);
        int          len;
        int          i;
        logic [63:0] rest;
        logic [7:0]  b;
        len  = 1;
        rest = value >> 7;
        while (rest != 0)
        begin
            len++;
            rest = rest >> 7;
        end
        if ($urandom_range(0, 7) == 0)
            len = $urandom_range(len, pvd_pkg::MAX_VARINT_BYTES);
        for (i = 0; i < len; i++)
        begin
            b = {1'b0, 7'(value >> (7 * i))};
            if (i == pvd_pkg::MAX_VARINT_BYTES - 1 && $urandom_range(0, 3) == 0)
                b[6:1] = 6'($urandom);
            if (i < len - 1)
                b[7] = 1'b1;
            put_byte(b);
        end
    endtask

    task automatic put_postings(input int n);
        repeat (n)
        begin
            put_varint($urandom_range(0, 1) ? 64'd0 : rand_value());
            put_varint($urandom_range(0, 2) == 0 ? 64'd0 : rand_value());
            put_varint(rand_value());
            put_varint(64'($urandom_range(0, 1)));
        end
    endtask

    task automatic close_block();
        if (block_bytes.size() == 0)
            put_byte(8'($urandom));
        block_bytes[block_bytes.size() - 1].block_end = 1'b1;
        items_pushed += block_bytes.size();
        foreach (block_bytes[i])
            byte_queue.insert(byte_queue.size(), block_bytes[i]);
        block_bytes.delete();
    endtask

    task automatic build_block(input block_kind_t kind, input logic [31:0] count);
        int n;
        n = (count > 6) ? $urandom_range(0, 6) : int'(count);
        case (kind)
            BLOCK_CLEAN:
                put_postings(n);
            BLOCK_SHORT:
            begin
                put_postings(n > 0 ? $urandom_range(0, n - 1) : 0);
                repeat ($urandom_range(0, 3))
                    put_varint(rand_value());
                if ($urandom_range(0, 1))
                    put_byte(8'h80 | 8'($urandom));
            end
            BLOCK_TRAILING:
            begin
                put_postings(n);
                repeat ($urandom_range(1, 3))
                    put_byte(8'($urandom));
            end
            BLOCK_BAD_STRAND:
            begin
                put_postings(n > 0 ? $urandom_range(0, n - 1) : 0);
                repeat (3)
                    put_varint(rand_value());
                put_varint(rand_value() | 64'd2);
                repeat ($urandom_range(0, 3))
                    put_byte(8'($urandom));
            end
            BLOCK_OVERLONG:
            begin
                put_postings(n > 0 ? $urandom_range(0, n - 1) : 0);
                repeat ($urandom_range(0, 2))
                    put_varint(rand_value());
                repeat (pvd_pkg::MAX_VARINT_BYTES)
                    put_byte(8'h80 | 8'($urandom));
                repeat ($urandom_range(0, 3))
                    put_byte(8'($urandom));
            end
            default:
                repeat ($urandom_range(1, 12))
                    put_byte(8'($urandom));
        endcase
    endtask

    task automatic wait_idle();
        while (items_accepted != items_pushed || expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_count(input logic [pvd_pkg::COUNT_W-1:0] value);
        wait_idle();
        @(negedge clk);
        count_we    = 1'b1;
        count_wdata = value;
        @(negedge clk);
        count_we        = 1'b0;
        postings_target = value;
        phase_no++;
    endtask

    function automatic logic [pvd_pkg::COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // byte acceptance feeds the predictor
    always @(posedge clk)
    begin
        byte_taken <= rst_n && byte_ch.valid && byte_ch.ready;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            items_accepted++;
            if (decode_byte(byte_ch.data_byte, byte_ch.block_end, predicted))
                expected_q.insert(expected_q.size(), predicted);
        end
    end

    // byte driver: bursts and gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            byte_ch.valid     <= 1'b0;
            byte_ch.data_byte <= '0;
            byte_ch.block_end <= 1'b0;
        end
        else if (!byte_ch.valid || byte_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left      <= gap_left - 1;
                byte_ch.valid <= 1'b0;
            end
            else if (byte_queue.size() != 0)
            begin
                next_byte          = byte_queue.pop_front();
                byte_ch.valid     <= 1'b1;
                byte_ch.data_byte <= next_byte.data_byte;
                byte_ch.block_end <= next_byte.block_end;
                if (burst_left > 1)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 16);
                    gap_left   <= $urandom_range(0, 6);
                end
            end
            else
                byte_ch.valid <= 1'b0;
        end
    end

    // result receiver: rotating stall pattern plus requested long hold-offs
    always @(negedge clk)
    begin
        if (!rst_n)
            post_ch.ready <= 1'b0;
        else
        begin
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (hold_served != hold_requests)
            begin
                hold_served <= hold_served + 1;
                hold_left   <= HOLD_CYCLES;
            end
            if (pattern_age == 0)
                stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
            else
                stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
            pattern_age   <= (pattern_age == 39) ? 0 : pattern_age + 1;
            post_ch.ready <= (hold_left == 0 && hold_served == hold_requests) ?
                             stall_pattern[0] : 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && post_ch.valid && post_ch.ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected item, block_done", 64'(post_ch.block_done), 64'd0);
            else
            begin
                want = expected_q.pop_front();
                if (post_ch.posting_valid !== want.posting_valid)
                    report_mismatch("posting_valid", 64'(post_ch.posting_valid),
                                    64'(want.posting_valid));
                if (post_ch.doc_id !== want.doc_id)
                    report_mismatch("doc_id", 64'(post_ch.doc_id), 64'(want.doc_id));
                if (post_ch.seq_id !== want.seq_id)
                    report_mismatch("seq_id", post_ch.seq_id, want.seq_id);
                if (post_ch.position !== want.position)
                    report_mismatch("position", post_ch.position, want.position);
                if (post_ch.strand !== want.strand)
                    report_mismatch("strand", 64'(post_ch.strand), 64'(want.strand));
                if (post_ch.block_done !== want.block_done)
                    report_mismatch("block_done", 64'(post_ch.block_done),
                                    64'(want.block_done));
                if (post_ch.status !== want.status)
                    report_mismatch("status", 64'(post_ch.status), 64'(want.status));
                if (want.posting_valid)
                    postings_checked++;
                if (want.block_done)
                begin
                    blocks_checked++;
                    status_count[int'(want.status)]++;
                end
            end
        end
    end

    initial
    begin
        int random_from;
        logic [pvd_pkg::COUNT_W-1:0] count;
        rst_n       = 1'b0;
        count_we    = 1'b0;
        count_wdata = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // widest document, first posting closes the block
        write_count(1);
        put_varint(64'hffff_ffff);
        put_varint(64'd0);
        put_varint(64'd0);
        put_varint(64'd1);
        close_block();
        // nothing allowed: first byte is trailing
        write_count(0);
        put_byte(8'h00);
        close_block();
        // same document and sequence, then a bad strand
        write_count(2);
        put_varint(64'd5);
        put_varint(64'd3);
        put_varint(64'd7);
        put_varint(64'd0);
        put_varint(64'd0);
        put_varint(64'd0);
        put_varint(64'd2);
        put_varint(64'd2);
        close_block();
        // block ends mid posting
        write_count(3);
        put_varint(64'd1);
        put_varint(64'd1);
        close_block();
        // overlong varint
        write_count(1);
        repeat (pvd_pkg::MAX_VARINT_BYTES)
            put_byte(8'hff);
        close_block();

        random_from = items_pushed;
        while (items_pushed - random_from < RANDOM_ITEMS)
        begin
            count = pick_count();
            write_count(count);
            if (phase_no == 8 || phase_no == 30)
                hold_requests++;
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 9))
                    5: build_block(BLOCK_SHORT, count);
                    6: build_block(BLOCK_TRAILING, count);
                    7: build_block(BLOCK_BAD_STRAND, count);
                    8: build_block(BLOCK_OVERLONG, count);
                    9: build_block(BLOCK_NOISE, count);
                    default: build_block(BLOCK_CLEAN, count);
                endcase
                close_block();
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        $display("Sent %0d bytes over %0d count settings; checked %0d postings, %0d blocks",
                 items_pushed, phase_no, postings_checked, blocks_checked);
        $display("Block status: ok %0d, overlong %0d, bad strand %0d, truncated %0d, trailing %0d",
                 status_count[0], status_count[1], status_count[2], status_count[3],
                 status_count[4]);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
